[rtl/core/lbs_pkg.sv]
// Package: shared constants and types for the skinning block.
package lbs_pkg;
    localparam int BONE_COUNT_DEF       = 256;
    localparam int BONES_PER_VERTEX_DEF = 4;
    localparam int COORD_BITS_DEF       = 16;
    localparam int MATRIX_BITS_DEF      = 32;
    localparam int SLOT_BITS            = 12;
    localparam int FIELD_BITS           = 48;
    localparam int WEIGHT_BITS          = 16;
    localparam int INDEX_BITS           = 32;
    localparam logic ACTION_WRITE       = 1'b0;
    localparam logic ACTION_SKIN        = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MAC  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;
endpackage

[rtl/core/lbs_mac.sv]
// Shared multiply-accumulate unit: one product per cycle into a 64-bit accumulator.
module lbs_mac #(
    parameter int A_BITS = 32,
    parameter int B_BITS = 32
) (
    input  logic                     clk,
    input  logic                     clear,
    input  logic                     enable,
    input  logic signed [A_BITS-1:0] a,
    input  logic signed [B_BITS-1:0] b,
    output logic signed [63:0]       acc
);
    logic signed [63:0] prod_reg;
    logic               pend_reg;
    logic signed [63:0] acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a * b);
        pend_reg <= enable;
        if (clear)
            acc_reg <= '0;
        else if (pend_reg)
            acc_reg <= acc_reg + prod_reg;
    end

    assign acc = acc_reg;
endmodule

[rtl/core/linear_blend_skinning.sv]
// Top level: four-bone linear blend skinning with a stored matrix palette.
// Usage: one input channel (valid/stall) carries either a palette element
// write (action 0) or a vertex to skin (action 1). Writes can follow back to
// back, and a write gives no result. A vertex gives one result on the output
// channel.
// A vertex whose first weight is zero is offered right after its input
// transfer. Otherwise each used bone takes 3 lanes x 2 vectors passes, each
// of one palette read, six multiply and drain steps over the four rows,
// one rounding step and one weighting step, with at most four bones. The
// next item is taken only once the result has been transferred and the
// sequencer is back in idle. All matrix products share the one
// multiply-accumulate unit, and palette reads come from a memory with one
// write and one read port, one element a cycle.
// The block takes no new item while a vertex is in work or its result waits.
// Reset clears the sequencer and the output valid. The palette is not
// cleared, and a vertex must only name bones whose elements were written.
// A stalled result holds its value until transferred, and a stall delays
// the next input.
module linear_blend_skinning
#(
    parameter int BONE_COUNT       = lbs_pkg::BONE_COUNT_DEF,
    parameter int BONES_PER_VERTEX = lbs_pkg::BONES_PER_VERTEX_DEF,
    parameter int COORD_BITS       = lbs_pkg::COORD_BITS_DEF,
    parameter int MATRIX_BITS      = lbs_pkg::MATRIX_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [lbs_pkg::SLOT_BITS-1:0]     palette_slot,
    input  logic signed [31:0]                matrix_value,
    input  logic [lbs_pkg::FIELD_BITS-1:0]    position,
    input  logic [lbs_pkg::FIELD_BITS-1:0]    normal_vector,
    input  logic [lbs_pkg::FIELD_BITS-1:0]    weights,
    input  logic [lbs_pkg::INDEX_BITS-1:0]    bone_indices,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lbs_pkg::FIELD_BITS-1:0]    skinned_position,
    output logic [lbs_pkg::FIELD_BITS-1:0]    skinned_normal,
    output logic                              passed_through
);
    import lbs_pkg::*;

    localparam int DEPTH  = BONE_COUNT * 16;
    localparam int ABITS  = $clog2(DEPTH);
    localparam int BBITS  = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int PLANES = 3 * COORD_BITS;

    logic signed [MATRIX_BITS-1:0] palette [DEPTH];
    logic signed [MATRIX_BITS-1:0] rd_reg;

    state_t state_reg, state_next;
    logic [FIELD_BITS-1:0] pos_reg, nrm_reg;
    logic [WEIGHT_BITS:0]  w_reg [4];
    logic [BBITS-1:0]      bone_reg [4];
    logic [1:0]            k_reg;      // bone
    logic [1:0]            c_reg;      // output lane
    logic                  v_reg;      // 0 position, 1 normal
    logic [2:0]            r_reg;      // row 0..3, 4..6 = drain
    logic signed [63:0]    accp_reg [3];
    logic signed [63:0]    accn_reg [3];
    logic signed [40:0]    t_reg;
    logic                  busy_reg;

    // Address of the element in work
    logic [ABITS-1:0] rd_addr;
    logic [ABITS+4:0] addr_full;
    always_comb
    begin
        addr_full = ((ABITS+5)'(bone_reg[k_reg]) << 4) + (ABITS+5)'({r_reg[1:0], c_reg});
        rd_addr   = addr_full[ABITS-1:0];
    end

    logic wr_en;
    logic in_acc;
    assign in_acc = in_valid && !in_stall;
    assign wr_en  = in_acc && (action == ACTION_WRITE) && (32'(palette_slot) < 32'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            palette[palette_slot[ABITS-1:0]] <= matrix_value[MATRIX_BITS-1:0];
        rd_reg <= palette[rd_addr];
    end

    // Multiplier operand: lane of row r (row 3 is w, 1.0 for position)
    logic signed [COORD_BITS+1:0] lane_op;
    logic [FIELD_BITS-1:0] vsel;
    assign vsel = v_reg ? nrm_reg : pos_reg;
    always_comb
    begin
        case (r_reg[1:0])
            2'd0: lane_op = (COORD_BITS+2)'($signed(vsel[COORD_BITS-1:0]));
            2'd1: lane_op = (COORD_BITS+2)'($signed(vsel[2*COORD_BITS-1:COORD_BITS]));
            2'd2: lane_op = (COORD_BITS+2)'($signed(vsel[PLANES-1:2*COORD_BITS]));
            default: lane_op = v_reg ? '0 : (COORD_BITS+2)'(256);
        endcase
    end

    logic lane_q_reg;
    logic signed [COORD_BITS+1:0] lane_q;
    logic mac_clear, mac_en;
    logic signed [63:0] mac_acc;
    logic signed [COORD_BITS+1:0] lane_d_reg;
    always_ff @(posedge clk)
    begin
        lane_d_reg <= lane_op;
        lane_q_reg <= (state_reg == ST_READ) || ((state_reg == ST_MAC) && (r_reg < 3'd4));
    end
    assign lane_q = lane_d_reg;
    assign mac_en = lane_q_reg;

    lbs_mac #(.A_BITS(COORD_BITS+2), .B_BITS(MATRIX_BITS)) u_mac (
        .clk    (clk),
        .clear  (mac_clear),
        .enable (mac_en),
        .a      (lane_q),
        .b      (rd_reg),
        .acc    (mac_acc)
    );

    logic signed [63:0] t_round;
    assign t_round = (mac_acc + 64'sd32768) >>> 16;

    logic signed [63:0] scaled;
    assign scaled = 64'(t_reg * $signed({1'b0, w_reg[k_reg]}));

    function automatic logic [COORD_BITS-1:0] sat(input logic signed [63:0] a);
        logic signed [63:0] v;
        logic signed [63:0] hi;
        v  = (a + 64'sd16384) >>> 15;
        hi = (64'sd1 <<< (COORD_BITS-1)) - 64'sd1;
        if (v > hi)
            return hi[COORD_BITS-1:0];
        else if (v < -hi - 64'sd1)
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        return v[COORD_BITS-1:0];
    endfunction

    assign in_stall  = busy_reg;
    assign mac_clear = (state_reg == ST_READ);

    logic [16:0] w0, w1, w2;
    logic signed [18:0] w3s;
    assign w0  = {1'b0, weights[15:0]};
    assign w1  = {1'b0, weights[31:16]};
    assign w2  = {1'b0, weights[47:32]};
    assign w3s = 19'sd32768 - 19'(w0) - 19'(w1) - 19'(w2);

    function automatic logic [BBITS-1:0] clamp_b(input logic [7:0] b);
        if (32'(b) >= BONE_COUNT)
            return BBITS'(BONE_COUNT - 1);
        return BBITS'(b);
    endfunction

    logic last_bone;
    assign last_bone = (32'(k_reg) + 1 >= BONES_PER_VERTEX) || (k_reg == 2'd3)
                       || (w_reg[k_reg + 2'd1] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && action == ACTION_SKIN)
                    begin
                        if (w0 == '0)
                        begin
                            out_valid <= 1'b1;
                            busy_reg  <= 1'b1;
                        end
                        else
                            busy_reg <= 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid)
                        out_valid <= 1'b1;
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        busy_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc && action == ACTION_SKIN)
                    state_next = (w0 == '0) ? ST_DONE : ST_READ;
            ST_READ:  state_next = ST_MAC;
            ST_MAC:   if (r_reg == 3'd6) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_SCALE;
            ST_SCALE:
                if (c_reg == 2'd2 && v_reg && last_bone)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            ST_DONE:
                if (out_valid && !out_stall)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // r_reg runs 0..3 issuing reads; 4..6 let the read and multiply drain
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && action == ACTION_SKIN)
                begin
                    pos_reg  <= position;
                    nrm_reg  <= normal_vector;
                    passed_through <= (w0 == '0);
                    skinned_position <= position;
                    skinned_normal   <= normal_vector;
                    w_reg[0] <= w0;
                    w_reg[1] <= w1;
                    w_reg[2] <= w2;
                    w_reg[3] <= w3s[18] ? '0 : w3s[16:0];
                    bone_reg[0] <= clamp_b(bone_indices[7:0]);
                    bone_reg[1] <= clamp_b(bone_indices[15:8]);
                    bone_reg[2] <= clamp_b(bone_indices[23:16]);
                    bone_reg[3] <= clamp_b(bone_indices[31:24]);
                    k_reg <= '0;
                    c_reg <= '0;
                    v_reg <= 1'b0;
                    r_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        accp_reg[i] <= '0;
                        accn_reg[i] <= '0;
                    end
                end
            end
            ST_READ:  r_reg <= 3'd1;
            ST_MAC:   r_reg <= r_reg + 3'd1;
            ST_ROUND: t_reg <= 41'(t_round);
            ST_SCALE:
            begin
                if (v_reg)
                    accn_reg[c_reg] <= accn_reg[c_reg] + scaled;
                else
                    accp_reg[c_reg] <= accp_reg[c_reg] + scaled;
                r_reg <= '0;
                v_reg <= !v_reg;
                if (v_reg)
                begin
                    if (c_reg == 2'd2)
                    begin
                        c_reg <= '0;
                        k_reg <= k_reg + 2'd1;
                    end
                    else
                        c_reg <= c_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid && !passed_through)
                begin
                    skinned_position <= {sat(accp_reg[2]), sat(accp_reg[1]), sat(accp_reg[0])};
                    skinned_normal   <= {sat(accn_reg[2]), sat(accn_reg[1]), sat(accn_reg[0])};
                end
            end
            default: ;
        endcase
    end

    // ST_READ issues row 0 while r_reg is 0; MAC issues rows 1..3
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result pending while input open");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !out_valid)
        else $error("result valid in idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return after transfer");
endmodule

[test/linear_blend_skinning_test.sv]
// Testbench for linear_blend_skinning: directed table, then random palette fills and vertices.
module linear_blend_skinning_test;
    import lbs_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int PHASE_ITEMS  = 400;

    typedef struct {
        logic        act;
        logic [11:0] slot;
        logic [31:0] mval;
        logic [47:0] pos;
        logic [47:0] nrm;
        logic [47:0] wts;
        logic [31:0] idx;
    } vert_item_t;

    typedef struct {
        logic [47:0] pos;
        logic [47:0] nrm;
        logic        pt;
    } skin_t;

    typedef struct {
        vert_item_t it;
        bit         typed;
        skin_t      exp;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [11:0] palette_slot;
    logic signed [31:0] matrix_value;
    logic [47:0] position;
    logic [47:0] normal_vector;
    logic [47:0] weights;
    logic [31:0] bone_indices;
    logic        out_valid;
    logic        out_stall;
    logic [47:0] skinned_position;
    logic [47:0] skinned_normal;
    logic        passed_through;

    logic signed [31:0] palette_model [0:4095];
    bit          slot_written [0:4095];
    bit          bone_ready [0:255];
    int          ready_bones [$];
    skin_t       pending_skins [$];
    table_row_t  directed_rows [$];
    int          errors;
    int          cycles;
    int          skins_checked;
    int          passthroughs_seen;
    int          writes_sent;
    bit          sender_idle;
    bit          recv_stall;
    int          fill_bone;
    int          fill_pos;

    linear_blend_skinning u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .palette_slot(palette_slot), .matrix_value(matrix_value),
        .position(position), .normal_vector(normal_vector), .weights(weights),
        .bone_indices(bone_indices),
        .out_valid(out_valid), .out_stall(out_stall),
        .skinned_position(skinned_position), .skinned_normal(skinned_normal),
        .passed_through(passed_through)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= recv_stall && ($urandom_range(99) < 57);

    function automatic logic [15:0] sat16(longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint elem(int bone, int row, int col);
        return longint'(palette_model[bone * 16 + row * 4 + col]);
    endfunction

    // Weighted sum of the row vector times each bone matrix, as the block computes it.
    function automatic skin_t skin_vertex(vert_item_t it);
        longint w [4];
        int     bone [4];
        longint accp [3];
        longint accn [3];
        longint tp;
        longint tn;
        skin_t  r;
        for (int k = 0; k < 3; k++)
            w[k] = longint'(it.wts[16*k +: 16]);
        w[3] = 32768 - w[0] - w[1] - w[2];
        if (w[3] < 0)
            w[3] = 0;
        if (w[0] == 0)
        begin
            r.pos = it.pos;
            r.nrm = it.nrm;
            r.pt = 1'b1;
            return r;
        end
        for (int k = 0; k < 4; k++)
        begin
            bone[k] = int'(it.idx[8*k +: 8]);
            if (bone[k] >= BONE_COUNT_DEF)
                bone[k] = BONE_COUNT_DEF - 1;
        end
        for (int c = 0; c < 3; c++)
        begin
            accp[c] = 0;
            accn[c] = 0;
        end
        for (int k = 0; k < BONES_PER_VERTEX_DEF; k++)
        begin
            if (w[k] == 0)
                break;
            for (int c = 0; c < 3; c++)
            begin
                tp = 256 * elem(bone[k], 3, c);
                tn = 0;
                for (int rw = 0; rw < 3; rw++)
                begin
                    tp += longint'($signed(it.pos[16*rw +: 16])) * elem(bone[k], rw, c);
                    tn += longint'($signed(it.nrm[16*rw +: 16])) * elem(bone[k], rw, c);
                end
                tp = (tp + 32768) >>> 16;
                tn = (tn + 32768) >>> 16;
                accp[c] += tp * w[k];
                accn[c] += tn * w[k];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            r.pos[16*c +: 16] = sat16((accp[c] + 16384) >>> 15);
            r.nrm[16*c +: 16] = sat16((accn[c] + 16384) >>> 15);
        end
        r.pt = 1'b0;
        return r;
    endfunction

    // Track which bones are fully written so vertices only name those.
    function automatic void note_write(logic [11:0] slot);
        int b;
        bit full;
        b = int'(slot) / 16;
        slot_written[slot] = 1'b1;
        full = 1'b1;
        for (int s = 0; s < 16; s++)
            if (!slot_written[b * 16 + s])
                full = 1'b0;
        if (full && !bone_ready[b])
        begin
            bone_ready[b] = 1'b1;
            ready_bones.insert(ready_bones.size(), b);
        end
    endfunction

    // Call at a rising edge; returns at the rising edge of the transfer, or later after a random idle gap.
    task automatic send(vert_item_t it, bit typed, skin_t exp);
        action <= it.act;
        palette_slot <= it.slot;
        matrix_value <= it.mval;
        position <= it.pos;
        normal_vector <= it.nrm;
        weights <= it.wts;
        bone_indices <= it.idx;
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (in_stall);
        if (it.act == ACTION_SKIN)
            pending_skins.insert(pending_skins.size(), typed ? exp : skin_vertex(it));
        else
        begin
            palette_model[it.slot] = it.mval;
            writes_sent++;
        end
        @(posedge clk);
        if (sender_idle && $urandom_range(99) < 57)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 57);
        end
    endtask

    function automatic logic [31:0] random_element(int slot_in_bone);
        int diag;
        diag = (slot_in_bone % 5 == 0) && (slot_in_bone < 15);
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(262143) - 131072;
            2: return diag ? 32'h0001_0000 + $urandom_range(8191) - 4096
                           : $urandom_range(16383) - 8192;
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic logic [47:0] random_vec();
        logic [47:0] v;
        if ($urandom_range(1))
            v = 48'({$urandom, $urandom});
        else
            for (int c = 0; c < 3; c++)
                v[16*c +: 16] = 16'($urandom_range(4095) - 2048);
        return v;
    endfunction

    function automatic vert_item_t random_item();
        vert_item_t it;
        int w0;
        int w1;
        int w2;
        it.slot = 12'($urandom);
        it.mval = $urandom;
        it.pos = random_vec();
        it.nrm = random_vec();
        it.idx = $urandom;
        it.wts = 48'({$urandom, $urandom});
        if (fill_pos < 0 && (ready_bones.size() < 2 || $urandom_range(99) < 5))
        begin
            case ($urandom_range(9))
                0: fill_bone = 0;
                1: fill_bone = 255;
                default: fill_bone = $urandom_range(255);
            endcase
            fill_pos = 0;
        end
        if (fill_pos >= 0 && (ready_bones.size() == 0 || $urandom_range(99) < 70))
        begin
            it.act = ACTION_WRITE;
            it.slot = 12'(fill_bone * 16 + fill_pos);
            it.mval = random_element(fill_pos);
            fill_pos = (fill_pos == 15) ? -1 : fill_pos + 1;
            note_write(it.slot);
            return it;
        end
        if ($urandom_range(99) < 6)
        begin
            // stray write anywhere in the palette
            it.act = ACTION_WRITE;
            it.mval = random_element($urandom_range(15));
            note_write(it.slot);
            return it;
        end
        it.act = ACTION_SKIN;
        for (int k = 0; k < 4; k++)
            it.idx[8*k +: 8] = 8'(ready_bones[$urandom_range(ready_bones.size() - 1)]);
        if ($urandom_range(99) < 10)
            it.wts[15:0] = 16'h0000;
        else if ($urandom_range(99) < 60)
        begin
            w0 = $urandom_range(32768, 1);
            w1 = ($urandom_range(99) < 15) ? 0 : $urandom_range(32768 - w0);
            w2 = ($urandom_range(99) < 15) ? 0 : $urandom_range(32768 - w0 - w1);
            it.wts = {16'(w2), 16'(w1), 16'(w0)};
        end
        return it;
    endfunction

    always @(negedge clk)
    begin
        skin_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_skins.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: pos %h nrm %h pt %b",
                         $time, skinned_position, skinned_normal, passed_through);
            end
            else
            begin
                e = pending_skins.pop_front();
                skins_checked++;
                if (passed_through)
                    passthroughs_seen++;
                if (skinned_position !== e.pos)
                begin
                    errors++;
                    $display("%0t: skinned_position expected %h actual %h",
                             $time, e.pos, skinned_position);
                end
                if (skinned_normal !== e.nrm)
                begin
                    errors++;
                    $display("%0t: skinned_normal expected %h actual %h",
                             $time, e.nrm, skinned_normal);
                end
                if (passed_through !== e.pt)
                begin
                    errors++;
                    $display("%0t: passed_through expected %b actual %b",
                             $time, e.pt, passed_through);
                end
            end
        end
    end

    task automatic add_row(logic act, logic [11:0] slot, logic [31:0] mval, logic [47:0] pos,
                           logic [47:0] nrm, logic [47:0] wts, bit typed, skin_t exp);
        table_row_t row;
        row.it = '{act: act, slot: slot, mval: mval, pos: pos, nrm: nrm, wts: wts,
                   idx: 32'h0000_0000};
        row.typed = typed;
        row.exp = exp;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial
    begin
        skin_t none;
        skin_t exp;
        vert_item_t it;
        none = '{pos: '0, nrm: '0, pt: 1'b0};
        errors = 0;
        cycles = 0;
        skins_checked = 0;
        passthroughs_seen = 0;
        writes_sent = 0;
        fill_pos = -1;
        fill_bone = 0;
        sender_idle = 1'b0;
        recv_stall = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = ACTION_WRITE;
        palette_slot = '0;
        matrix_value = '0;
        position = '0;
        normal_vector = '0;
        weights = '0;
        bone_indices = '0;
        for (int s = 0; s < 4096; s++)
        begin
            palette_model[s] = '0;
            slot_written[s] = 1'b0;
        end
        for (int b = 0; b < 256; b++)
            bone_ready[b] = 1'b0;

        // bone 0 is identity; then the extreme element values
        for (int s = 0; s < 16; s++)
            add_row(ACTION_WRITE, 12'(s), (s % 5 == 0) ? 32'h0001_0000 : 32'h0,
                    '0, '0, '0, 1'b0, none);
        add_row(ACTION_WRITE, 12'd16, 32'h8000_0000, '0, '0, '0, 1'b0, none);
        add_row(ACTION_WRITE, 12'd4095, 32'h7fff_ffff, '0, '0, '0, 1'b0, none);
        // first weight zero: copied unchanged
        exp = '{pos: 48'hffff_ffff_ffff, nrm: 48'h0, pt: 1'b1};
        add_row(ACTION_SKIN, '0, '0, 48'hffff_ffff_ffff, 48'h0, 48'hffff_ffff_0000, 1'b1, exp);
        // full weight on identity: vector comes back as is
        exp = '{pos: 48'h8000_7fff_0001, nrm: 48'h0100_ff00_8000, pt: 1'b0};
        add_row(ACTION_SKIN, '0, '0, 48'h8000_7fff_0001, 48'h0100_ff00_8000,
                48'h0000_0000_8000, 1'b1, exp);
        add_row(ACTION_SKIN, '0, '0, 48'h1234_8000_7fff, 48'hffff_0001_8000,
                48'hffff_ffff_ffff, 1'b0, none);
        add_row(ACTION_SKIN, '0, '0, 48'h7fff_7fff_7fff, 48'h8000_8000_8000,
                48'h0001_0001_0001, 1'b0, none);
        add_row(ACTION_SKIN, '0, '0, 48'h0400_fc00_0180, 48'h0100_0000_ff00,
                48'h0000_4000_4000, 1'b0, none);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].it.act == ACTION_WRITE)
                note_write(directed_rows[i].it.slot);
            send(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].exp);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            // hold off until the block has drained
            in_valid <= 1'b0;
            while (pending_skins.size() != 0)
                @(posedge clk);
            sender_idle = (phase == 1) || (phase == 3);
            recv_stall = (phase == 2) || (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = random_item();
                send(it, 1'b0, none);
            end
        end
        in_valid <= 1'b0;
        while (pending_skins.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d palette writes and %0d skinned vertices (%0d passed through),",
                 writes_sent, skins_checked, passthroughs_seen);
        $display("across %0d fully written bones and four idle/stall mixes.",
                 ready_bones.size());
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
